>>> src/bbd_pkg.sv
// Shared types, constants and functions for the binary to decimal digit converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

    localparam int unsigned ValueWidth   = 32;
    localparam int unsigned NumDigits    = 10;
    localparam int unsigned BcdWidth     = 4 * NumDigits;
    localparam int unsigned BitsPerStage = 4;
    localparam int unsigned NumStages    = ValueWidth / BitsPerStage;

    localparam logic [5:0] AsciiZero = 6'd48;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_WORD = 2'd1,
        KIND_LONG = 2'd2
    } kind_t;

    // one word in flight through the shift-add-3 pipeline
    typedef struct packed {
        logic [1:0]            kind;
        logic [15:0]           offset;
        logic [ValueWidth-1:0] bin;
        logic [BcdWidth-1:0]   bcd;
    } work_t;

    // one shift-add-3 step: correct each digit, then shift in the next binary bit
    function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                        input logic            b);
        logic [BcdWidth-1:0] adj;
        logic [3:0]          d;
        for (int i = 0; i < NumDigits; i++) begin
            d = bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return {adj[BcdWidth-2:0], b};
    endfunction

    // index of the most significant digit sent for a kind
    function automatic logic [3:0] top_digit(input logic [1:0] kind);
        logic [3:0] idx;
        case (kind)
            KIND_BYTE: idx = 4'd2;
            KIND_WORD: idx = 4'd4;
            default:   idx = 4'd9;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> src/binary_to_decimal_digits.sv
// Top level: binary to decimal ASCII digits with screen positions.
// Depends on bbd_pkg, bbd_dabble_stage, bbd_serializer.
//
//   channel  dir  tdata                               tuser      tlast
//   s_       in   [15:0] screen_offset [47:16] value  [1:0] kind  -
//   m_       out  [5:0] char_code [21:6] position     -          last digit
//
// Eight shift-add-3 stages (4 bits each), then a serializer.
// A word yields 3, 5 or 10 digits by kind; the serializer's single output port sends them.
// Pipeline stages keep accepting words while the serializer is busy, until they fill.
// aresetn (synchronous) clears valid bits, serializer busy flag and digit index only;
// stalls hold every stage.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_digits (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [15:0] screen_offset, [47:16] value
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] char_code, [21:6] position, [23:22] zero
    output logic             m_tlast
);

    localparam int unsigned N = bbd_pkg::NumStages;

    logic           st_valid [0:N];
    logic           st_ready [0:N];
    bbd_pkg::work_t st_data  [0:N];
    logic [31:0]    masked;

    always_comb begin
        case (s_tuser)
            bbd_pkg::KIND_BYTE: masked = {24'd0, s_tdata[23:16]};
            bbd_pkg::KIND_WORD: masked = {16'd0, s_tdata[31:16]};
            default:            masked = s_tdata[47:16];
        endcase
    end

    assign st_valid[0]       = s_tvalid;
    assign s_tready          = st_ready[0];
    assign st_data[0].kind   = s_tuser;
    assign st_data[0].offset = s_tdata[15:0];
    assign st_data[0].bin    = masked;
    assign st_data[0].bcd    = '0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        bbd_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    bbd_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_valid[N]),
        .in_ready (st_ready[N]),
        .in_data  (st_data[N]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/bbd_dabble_stage.sv
// One pipeline stage of the binary to BCD converter: BitsPerStage shift-add-3 steps.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_dabble_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bbd_pkg::work_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bbd_pkg::work_t     out_data
);

    logic           valid_reg;
    bbd_pkg::work_t data_reg;
    bbd_pkg::work_t data_next;

    always_comb begin
        data_next = in_data;
        for (int s = 0; s < bbd_pkg::BitsPerStage; s++) begin
            data_next.bcd = bbd_pkg::dabble_step(data_next.bcd,
                                                 data_next.bin[bbd_pkg::ValueWidth-1]);
            data_next.bin = {data_next.bin[bbd_pkg::ValueWidth-2:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> src/bbd_serializer.sv
// Digit serializer: sends a word's BCD digits most significant first, one per cycle unless stalled.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_serializer (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bbd_pkg::work_t in_data,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tlast
);

    logic                          busy_reg, busy_next;
    logic [3:0]                    idx_reg, idx_next;
    logic [15:0]                   pos_reg, pos_next;
    logic [bbd_pkg::BcdWidth-1:0]  bcd_reg, bcd_next;
    logic                          m_valid_reg, m_valid_next;
    logic [5:0]                    char_reg, char_next;
    logic [15:0]                   opos_reg, opos_next;
    logic                          last_reg, last_next;
    logic                          out_free;
    logic [3:0]                    digit;

    assign out_free = !m_valid_reg || m_tready;
    assign in_ready = !busy_reg || (out_free && idx_reg == 4'd0);
    assign digit    = bcd_reg[{idx_reg, 2'b00} +: 4];

    always_comb begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        bcd_next     = bcd_reg;
        m_valid_next = m_valid_reg && !m_tready;
        char_next    = char_reg;
        opos_next    = opos_reg;
        last_next    = last_reg;
        if (busy_reg && out_free) begin
            m_valid_next = 1'b1;
            char_next    = bbd_pkg::AsciiZero + {2'b00, digit};
            opos_next    = pos_reg;
            last_next    = (idx_reg == 4'd0);
            if (idx_reg == 4'd0) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg - 4'd1;
                pos_next = pos_reg + 16'd1;
            end
        end
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            idx_next  = bbd_pkg::top_digit(in_data.kind);
            pos_next  = in_data.offset;
            bcd_next  = in_data.bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= 4'd0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        opos_reg <= opos_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, opos_reg, char_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> src/bbd_checker.sv
// Port-level checks for binary_to_decimal_digits, bound to the top level.
// Depends on binary_to_decimal_digits ports only.
`timescale 1ns / 1ps
`default_nettype none

module bbd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] >= 6'd48) && (m_tdata[5:0] <= 6'd57))
        else $error("char code not a decimal digit");

    // inside a run the next digit follows at once at the next position
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[21:6] == $past(m_tdata[21:6]) + 16'd1))
        else $error("run broken or position not incremented");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind binary_to_decimal_digits bbd_checker u_bbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
